// ----- src/svpwm_pkg.sv -----
// Shared types, constants and helper functions for the SVPWM phase duty generator.
// Holds the quarter-wave sine table built at elaboration. Depends on nothing.
package svpwm_pkg;

    // Block constants
    localparam int SINE_ENTRIES   = 1024;
    localparam int SINE_AMPLITUDE = 1024;
    localparam int ENCODER_COUNTS = 16384;
    localparam int POLE_COUNT     = 14;

    localparam int FULL_SCALE     = 1024;
    localparam int FS_SH          = 10;
    localparam int HALF_SCALE     = FULL_SCALE / 2;
    localparam int SQRT3_NUM      = 1773;
    localparam int SQRT3_SH       = 11;
    localparam int INV_SQRT3_NUM  = 591;
    localparam int INV_SQRT3_SH   = 10;
    localparam int AMP_SH         = $clog2(SINE_AMPLITUDE);

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] Q30_ONE     = 64'd1073741824;

    // Electrical index = angle * THETA_NUM / THETA_DEN, wrapped to the table size
    localparam int THETA_NUM = POLE_COUNT * SINE_ENTRIES;
    localparam int THETA_DEN = 2 * ENCODER_COUNTS;

    // Field and datapath widths
    localparam int TRQ_W   = 12;
    localparam int ANG_W   = 14;
    localparam int PER_W   = 16;
    localparam int IDX_W   = $clog2(SINE_ENTRIES);
    localparam int QTR     = SINE_ENTRIES / 4;
    localparam int HALF    = SINE_ENTRIES / 2;
    localparam int QIDX_W  = $clog2(QTR + 1);
    localparam int MAG_W   = $clog2(SINE_AMPLITUDE + 1);
    localparam int SIN_W   = MAG_W + 1;
    localparam int PRD_W   = TRQ_W + SIN_W;
    localparam int AX_W    = TRQ_W + 1;
    localparam int PH_W    = AX_W + 1;
    localparam int DIF_W   = PH_W + 1;
    localparam int V_W     = 14;

    localparam int NSTG    = 6;

    localparam logic [PER_W-1:0] TIMER_PERIOD_RST = PER_W'(1024);

    typedef logic [MAG_W-1:0] t_sin_tab [0:QTR];

    // Words passed between pipeline stages
    typedef struct packed {
        logic signed [TRQ_W-1:0] torque_cmd;
        logic                    brake_mode;
        logic [ANG_W-1:0]        mech_angle;
        logic                    motor_select;
    } t_cmd;

    typedef struct packed {
        logic signed [TRQ_W-1:0] torque_cmd;
        logic                    brake_mode;
        logic                    motor_select;
        logic signed [SIN_W-1:0] sin_val;
        logic signed [SIN_W-1:0] cos_val;
    } t_trig;

    typedef struct packed {
        logic signed [AX_W-1:0] alpha;
        logic signed [AX_W-1:0] beta;
        logic                   motor_select;
    } t_axes;

    typedef struct packed {
        logic signed [PH_W-1:0] pa;
        logic signed [PH_W-1:0] pb;
        logic signed [PH_W-1:0] pc;
        logic                   motor_select;
    } t_phase;

    typedef struct packed {
        logic signed [DIF_W-1:0] da;
        logic signed [DIF_W-1:0] db;
        logic signed [DIF_W-1:0] dc;
        logic                    motor_select;
    } t_diff;

    typedef struct packed {
        logic signed [V_W-1:0] va;
        logic signed [V_W-1:0] vb;
        logic signed [V_W-1:0] vc;
        logic                  motor_select;
    } t_volt;

    typedef struct packed {
        logic [PER_W-1:0] duty_first;
        logic [PER_W-1:0] duty_second;
        logic [PER_W-1:0] duty_third;
        logic             motor_tag;
    } t_duty;

    // Signed division by 2**sh that truncates toward zero.
    function automatic logic signed [31:0] sdiv_pow2(input logic signed [31:0] x,
                                                     input int unsigned sh);
        logic signed [31:0] bias;
        bias = x[31] ? ((32'sd1 <<< sh) - 32'sd1) : 32'sd0;
        return (x + bias) >>> sh;
    endfunction

    // First-quadrant sine magnitudes: Q30 Taylor series to the x^15 term,
    // truncating shifts, half-up rounding to the amplitude scale.
    function automatic t_sin_tab build_sin_tab();
        t_sin_tab    tab;
        logic [63:0] t;
        logic [63:0] x;
        logic [63:0] term;
        longint      sum;
        longint      mag;
        for (int j = 0; j <= QTR; j++) begin
            t    = (64'(j) << 32) / 64'(SINE_ENTRIES);
            x    = (t * HALF_PI_Q30) >> 30;
            sum  = longint'(x);
            term = x;
            for (int k = 1; k <= 7; k++) begin
                term = (term * x) >> 30;
                term = (term * x) >> 30;
                term = term / 64'((2 * k) * (2 * k + 1));
                if ((k % 2) == 1) begin
                    sum = sum - longint'(term);
                end else begin
                    sum = sum + longint'(term);
                end
            end
            if (sum < 0) begin
                sum = 0;
            end
            mag = longint'((64'(sum) * 64'(SINE_AMPLITUDE) + (Q30_ONE >> 1)) >> 30);
            if (mag > SINE_AMPLITUDE) begin
                mag = SINE_AMPLITUDE;
            end
            tab[j] = MAG_W'(mag);
        end
        return tab;
    endfunction

    localparam t_sin_tab SIN_TAB = build_sin_tab();

endpackage

// ----- src/svpwm_if.sv -----
// Valid/ready channel interfaces for the command and duty words.
// Depends on svpwm_pkg for field widths.
interface svpwm_cmd_if import svpwm_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [TRQ_W-1:0] torque_cmd;
    logic                    brake_mode;
    logic [ANG_W-1:0]        mech_angle;
    logic                    motor_select;

    modport source (output valid, output torque_cmd, output brake_mode,
                    output mech_angle, output motor_select, input ready);
    modport sink   (input valid, input torque_cmd, input brake_mode,
                    input mech_angle, input motor_select, output ready);
endinterface

interface svpwm_duty_if import svpwm_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PER_W-1:0] duty_first;
    logic [PER_W-1:0] duty_second;
    logic [PER_W-1:0] duty_third;
    logic             motor_tag;

    modport source (output valid, output duty_first, output duty_second,
                    output duty_third, output motor_tag, input ready);
    modport sink   (input valid, input duty_first, input duty_second,
                    input duty_third, input motor_tag, output ready);
endinterface

// ----- src/svpwm_angle_lut.sv -----
// Stage one: mechanical angle to electrical index, sine and cosine lookup.
// Depends on svpwm_pkg for the quarter-wave table and word types.
module svpwm_angle_lut import svpwm_pkg::*; (
    input  logic  i_clk,
    input  logic  i_en,
    input  t_cmd  i_cmd,
    output t_trig o_trig
);

    t_trig              r_trig;
    t_trig              n_trig;
    logic [31:0]        theta_full;
    logic [IDX_W-1:0]   idx_sin;
    logic [IDX_W-1:0]   idx_cos;

    // Fold a full-turn index onto the quarter-wave table and restore the sign.
    function automatic logic signed [SIN_W-1:0] trig_at(input logic [IDX_W-1:0] idx);
        logic [IDX_W-2:0]  h;
        logic [QIDX_W-1:0] q;
        logic [MAG_W-1:0]  m;
        h = idx[IDX_W-2:0];
        if (int'(h) > QTR) begin
            q = QIDX_W'(HALF - int'(h));
        end else begin
            q = QIDX_W'(h);
        end
        m = SIN_TAB[q];
        return idx[IDX_W-1] ? -$signed({1'b0, m}) : $signed({1'b0, m});
    endfunction

    assign theta_full = (32'(i_cmd.mech_angle) * 32'(THETA_NUM)) / THETA_DEN;
    assign idx_sin    = theta_full[IDX_W-1:0];
    assign idx_cos    = idx_sin + IDX_W'(QTR);

    always_comb begin
        n_trig.torque_cmd   = i_cmd.torque_cmd;
        n_trig.brake_mode   = i_cmd.brake_mode;
        n_trig.motor_select = i_cmd.motor_select;
        n_trig.sin_val      = trig_at(idx_sin);
        n_trig.cos_val      = trig_at(idx_cos);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_trig <= n_trig;
        end
    end

    assign o_trig = r_trig;

endmodule

// ----- src/svpwm_park_clarke.sv -----
// Stages two and three: inverse Park into alpha/beta, then inverse Clarke
// into three phase voltages. Depends on svpwm_pkg.
module svpwm_park_clarke import svpwm_pkg::*; (
    input  logic       i_clk,
    input  logic [1:0] i_en,
    input  t_trig      i_trig,
    output t_phase     o_phase
);

    t_axes                   r_axes;
    t_axes                   n_axes;
    t_phase                  r_phase;
    t_phase                  n_phase;
    logic signed [PRD_W-1:0] p_c;
    logic signed [PRD_W-1:0] p_s;
    logic signed [PRD_W-1:0] num_a;
    logic signed [PRD_W-1:0] num_b;
    logic signed [31:0]      half_a;
    logic signed [31:0]      k_beta;

    // Only one of d and q is nonzero, so each axis needs a single product.
    assign p_c   = PRD_W'(i_trig.torque_cmd) * PRD_W'(i_trig.cos_val);
    assign p_s   = PRD_W'(i_trig.torque_cmd) * PRD_W'(i_trig.sin_val);
    assign num_a = i_trig.brake_mode ? -p_s : p_c;
    assign num_b = i_trig.brake_mode ? p_c : p_s;

    always_comb begin
        n_axes.alpha        = AX_W'(sdiv_pow2(32'(num_a), AMP_SH));
        n_axes.beta         = AX_W'(sdiv_pow2(32'(num_b), AMP_SH));
        n_axes.motor_select = i_trig.motor_select;
    end

    assign half_a = sdiv_pow2(32'(r_axes.alpha), 1);
    assign k_beta = sdiv_pow2(32'(r_axes.beta) * 32'(SQRT3_NUM), SQRT3_SH);

    always_comb begin
        n_phase.pa           = PH_W'(r_axes.alpha);
        n_phase.pb           = PH_W'(k_beta - half_a);
        n_phase.pc           = PH_W'(-half_a - k_beta);
        n_phase.motor_select = r_axes.motor_select;
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_axes <= n_axes;
        end
        if (i_en[1]) begin
            r_phase <= n_phase;
        end
    end

    assign o_phase = r_phase;

endmodule

// ----- src/svpwm_mid_inject.sv -----
// Stage four: min/max midpoint removal from the three phase voltages.
// Depends on svpwm_pkg.
module svpwm_mid_inject import svpwm_pkg::*; (
    input  logic   i_clk,
    input  logic   i_en,
    input  t_phase i_phase,
    output t_diff  o_diff
);

    t_diff                  r_diff;
    t_diff                  n_diff;
    logic signed [PH_W-1:0] lo_ab;
    logic signed [PH_W-1:0] hi_ab;
    logic signed [PH_W-1:0] lo;
    logic signed [PH_W-1:0] hi;
    logic signed [31:0]     com;

    assign lo_ab = (i_phase.pa <= i_phase.pb) ? i_phase.pa : i_phase.pb;
    assign hi_ab = (i_phase.pa >= i_phase.pb) ? i_phase.pa : i_phase.pb;
    assign lo    = (lo_ab <= i_phase.pc) ? lo_ab : i_phase.pc;
    assign hi    = (hi_ab >= i_phase.pc) ? hi_ab : i_phase.pc;
    assign com   = sdiv_pow2(32'(lo) + 32'(hi), 1);

    always_comb begin
        n_diff.da           = DIF_W'(32'(i_phase.pa) - com);
        n_diff.db           = DIF_W'(32'(i_phase.pb) - com);
        n_diff.dc           = DIF_W'(32'(i_phase.pc) - com);
        n_diff.motor_select = i_phase.motor_select;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_diff <= n_diff;
        end
    end

    assign o_diff = r_diff;

endmodule

// ----- src/svpwm_duty_scale.sv -----
// Stages five and six: 1/sqrt3 scaling with half-scale offset, then scaling
// to the PWM period, clamping and phase ordering. Depends on svpwm_pkg.
module svpwm_duty_scale import svpwm_pkg::*; (
    input  logic             i_clk,
    input  logic [1:0]       i_en,
    input  logic [PER_W-1:0] i_timer_period,
    input  t_diff            i_diff,
    output t_duty            o_duty
);

    t_volt              r_volt;
    t_volt              n_volt;
    t_duty              r_duty;
    t_duty              n_duty;
    logic signed [31:0] per_s;
    logic [PER_W-1:0]   duty_a;
    logic [PER_W-1:0]   duty_b;
    logic [PER_W-1:0]   duty_c;

    function automatic logic signed [V_W-1:0] to_volt(input logic signed [DIF_W-1:0] d);
        return V_W'(sdiv_pow2(32'(d) * 32'(INV_SQRT3_NUM), INV_SQRT3_SH) + 32'(HALF_SCALE));
    endfunction

    function automatic logic [PER_W-1:0] to_duty(input logic signed [V_W-1:0] v,
                                                 input logic signed [31:0] per);
        logic signed [31:0] w;
        w = sdiv_pow2(32'(v) * per, FS_SH);
        priority if (per == 32'sd0) begin
            return '0;
        end else if (w < 32'sd0) begin
            return '0;
        end else if (w > per - 32'sd1) begin
            return PER_W'(per - 32'sd1);
        end else begin
            return PER_W'(w);
        end
    endfunction

    always_comb begin
        n_volt.va           = to_volt(i_diff.da);
        n_volt.vb           = to_volt(i_diff.db);
        n_volt.vc           = to_volt(i_diff.dc);
        n_volt.motor_select = i_diff.motor_select;
    end

    assign per_s  = $signed(32'(i_timer_period));
    assign duty_a = to_duty(r_volt.va, per_s);
    assign duty_b = to_duty(r_volt.vb, per_s);
    assign duty_c = to_duty(r_volt.vc, per_s);

    // The left motor is wired with phases a and b swapped.
    always_comb begin
        if (r_volt.motor_select) begin
            n_duty.duty_first  = duty_a;
            n_duty.duty_second = duty_b;
        end else begin
            n_duty.duty_first  = duty_b;
            n_duty.duty_second = duty_a;
        end
        n_duty.duty_third = duty_c;
        n_duty.motor_tag  = r_volt.motor_select;
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_volt <= n_volt;
        end
        if (i_en[1]) begin
            r_duty <= n_duty;
        end
    end

    assign o_duty = r_duty;

endmodule

// ----- src/svpwm_phase_duty_generator.sv -----
// Top level of the SVPWM phase duty generator: six-stage pipeline with
// per-stage valid bits and the period register. Depends on svpwm_pkg,
// svpwm_if and the four stage modules.
//
//   channel   direction  word                                         handshake
//   i_cmd     in         torque_cmd, brake_mode, mech_angle, motor    valid/ready
//   o_duty    out        duty_first, duty_second, duty_third, tag     valid/ready
//   i_cfg_*   in         timer period                                 write enable
//
// One word is accepted per cycle while the output is not stalled; each result
// passes through the six register stages of the datapath before it is presented.
// Reset clears the valid bits and loads a period of 1024 counts.
// A stalled output holds its word; a stage takes a new word whenever it is
// empty or the stage after it moves, so bubbles are squeezed out.
module svpwm_phase_duty_generator import svpwm_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    svpwm_cmd_if.sink        i_cmd,
    svpwm_duty_if.source     o_duty,
    input  logic             i_cfg_we,
    input  logic [PER_W-1:0] i_cfg_wdata
);

    logic [PER_W-1:0] r_timer_period;
    logic [NSTG-1:0]  r_vld;
    logic [NSTG-1:0]  n_vld;
    logic [NSTG-1:0]  en;
    t_cmd             cmd_word;
    t_trig            trig_word;
    t_phase           phase_word;
    t_diff            diff_word;
    t_duty            duty_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timer_period <= TIMER_PERIOD_RST;
        end else if (i_cfg_we) begin
            r_timer_period <= i_cfg_wdata;
        end
    end

    // A stage loads when it is empty or its contents move on.
    always_comb begin
        en[NSTG-1] = !r_vld[NSTG-1] || o_duty.ready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    always_comb begin
        n_vld    = r_vld;
        if (en[0]) begin
            n_vld[0] = i_cmd.valid;
        end
        for (int k = 1; k < NSTG; k++) begin
            if (en[k]) begin
                n_vld[k] = r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign i_cmd.ready = en[0];

    always_comb begin
        cmd_word.torque_cmd   = i_cmd.torque_cmd;
        cmd_word.brake_mode   = i_cmd.brake_mode;
        cmd_word.mech_angle   = i_cmd.mech_angle;
        cmd_word.motor_select = i_cmd.motor_select;
    end

    svpwm_angle_lut u_angle_lut (
        .i_clk  (i_clk),
        .i_en   (en[0]),
        .i_cmd  (cmd_word),
        .o_trig (trig_word)
    );

    svpwm_park_clarke u_park_clarke (
        .i_clk   (i_clk),
        .i_en    (en[2:1]),
        .i_trig  (trig_word),
        .o_phase (phase_word)
    );

    svpwm_mid_inject u_mid_inject (
        .i_clk   (i_clk),
        .i_en    (en[3]),
        .i_phase (phase_word),
        .o_diff  (diff_word)
    );

    svpwm_duty_scale u_duty_scale (
        .i_clk          (i_clk),
        .i_en           (en[5:4]),
        .i_timer_period (r_timer_period),
        .i_diff         (diff_word),
        .o_duty         (duty_word)
    );

    assign o_duty.valid       = r_vld[NSTG-1];
    assign o_duty.duty_first  = duty_word.duty_first;
    assign o_duty.duty_second = duty_word.duty_second;
    assign o_duty.duty_third  = duty_word.duty_third;
    assign o_duty.motor_tag   = duty_word.motor_tag;

    // Every duty stays below a nonzero period.
    a_duty_below_period: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_duty.valid && (r_timer_period != '0) |->
            (o_duty.duty_first < r_timer_period) && (o_duty.duty_second < r_timer_period)
            && (o_duty.duty_third < r_timer_period))
        else $error("duty word at or above the PWM period");

    // A zero period forces all duties to zero.
    a_zero_period: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_duty.valid && (r_timer_period == '0) |->
            (o_duty.duty_first == '0) && (o_duty.duty_second == '0)
            && (o_duty.duty_third == '0))
        else $error("nonzero duty with zero period");

    // An accepted command always occupies the first stage next cycle.
    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.valid && i_cmd.ready |=> r_vld[0])
        else $error("accepted command lost at the first stage");

    // Input back-pressure only when the whole pipe is full and the output is blocked.
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cmd.ready |-> (&r_vld) && !o_duty.ready)
        else $error("input stalled while the pipeline has room");

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for svpwm_phase_duty_generator: predicts each duty word
// from the command word and the period register. Depends on svpwm_pkg and svpwm_if.
module tb_top import svpwm_pkg::*; ();

    // Cycles to let the datapath settle after the last expected word.
    localparam int SETTLE_CYCLES = NSTG + 4;
    localparam int PHASE_ITEMS   = 125;

    typedef struct {
        t_cmd cmd;
        bit   hold;
    } t_pending_cmd;

    typedef enum int {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_PERIODIC} t_rx_mode;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_we;
    logic [PER_W-1:0] cfg_wdata;
    logic [PER_W-1:0] period_now;

    svpwm_cmd_if  cmd_ch ();
    svpwm_duty_if duty_ch ();

    t_pending_cmd cmd_pend[$];
    t_duty        duty_expect[$];

    int       n_sent     = 0;
    int       n_taken    = 0;
    int       n_checked  = 0;
    int       n_err      = 0;
    int       n_holds    = 0;
    int       n_brake    = 0;
    int       n_settings = 1;
    int       burst_left = 1;
    int       gap_left   = 0;
    int       rx_count   = 0;
    t_rx_mode rx_mode    = RX_OPEN;
    bit       cmd_fire   = 1'b0;

    always #5 clk = ~clk;

    svpwm_phase_duty_generator DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cmd       (cmd_ch),
        .o_duty      (duty_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    // Sine of a Q32 turn fraction at table amplitude, by the folded Taylor series.
    function automatic longint sine_of_turn(input logic [63:0] frac);
        logic [63:0] x;
        logic [63:0] term;
        longint      acc;
        longint      mag;
        logic        neg;
        int          k;
        frac = frac & 64'hFFFF_FFFF;
        neg  = 1'b0;
        if (frac >= 64'h8000_0000) begin
            neg  = 1'b1;
            frac = frac - 64'h8000_0000;
        end
        if (frac > 64'h4000_0000) begin
            frac = 64'h8000_0000 - frac;
        end
        x    = (frac * HALF_PI_Q30) >> 30;
        acc  = longint'(x);
        term = x;
        for (k = 1; k <= 7; k++) begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            term = term / 64'((2 * k) * (2 * k + 1));
            if ((k % 2) == 1) begin
                acc = acc - longint'(term);
            end else begin
                acc = acc + longint'(term);
            end
        end
        if (acc < 0) begin
            acc = 0;
        end
        mag = longint'((64'(acc) * 64'(SINE_AMPLITUDE) + (Q30_ONE >> 1)) >> 30);
        if (mag > SINE_AMPLITUDE) begin
            mag = SINE_AMPLITUDE;
        end
        return neg ? -mag : mag;
    endfunction

    // Centered phase voltage to a compare value clamped below the period.
    function automatic logic [PER_W-1:0] phase_to_duty(input longint ph, input longint mid,
                                                      input logic [PER_W-1:0] per);
        longint v;
        longint p;
        p = longint'(per);
        v = ((ph - mid) * INV_SQRT3_NUM) / 1024 + FULL_SCALE / 2;
        v = (v * p) / FULL_SCALE;
        if (p == 0) begin
            return '0;
        end
        if (v < 0) begin
            v = 0;
        end
        if (v > p - 1) begin
            v = p - 1;
        end
        return PER_W'(v);
    endfunction

    function automatic t_duty predict_duty(input logic signed [TRQ_W-1:0] trq,
                                           input logic brk, input logic [ANG_W-1:0] ang,
                                           input logic mot, input logic [PER_W-1:0] per);
        longint      tq;
        longint      q_ax;
        longint      d_ax;
        longint      s;
        longint      c;
        longint      alpha;
        longint      beta;
        longint      pa;
        longint      pb;
        longint      pc;
        longint      lo;
        longint      hi;
        longint      mid;
        logic [63:0] elec;
        logic [63:0] frac;
        logic [PER_W-1:0] da;
        logic [PER_W-1:0] db;
        t_duty       r;
        tq   = trq;
        q_ax = brk ? tq : 0;
        d_ax = brk ? 0 : tq;
        elec = (64'(ang) * 64'(POLE_COUNT) * 64'(SINE_ENTRIES)) / 64'(2 * ENCODER_COUNTS);
        elec = elec % 64'(SINE_ENTRIES);
        frac = (elec << 32) / 64'(SINE_ENTRIES);
        s    = sine_of_turn(frac);
        c    = sine_of_turn(frac + Q30_ONE);
        alpha = (d_ax * c - q_ax * s) / SINE_AMPLITUDE;
        beta  = (d_ax * s + q_ax * c) / SINE_AMPLITUDE;
        pa = alpha;
        pb = -(alpha / 2) + (SQRT3_NUM * beta) / 2048;
        pc = -(alpha / 2) - (SQRT3_NUM * beta) / 2048;
        lo = (pa < pb) ? pa : pb;
        lo = (pc < lo) ? pc : lo;
        hi = (pa > pb) ? pa : pb;
        hi = (pc > hi) ? pc : hi;
        mid = (lo + hi) / 2;
        da = phase_to_duty(pa, mid, per);
        db = phase_to_duty(pb, mid, per);
        // The left motor swaps the first two channels.
        r.duty_first  = mot ? da : db;
        r.duty_second = mot ? db : da;
        r.duty_third  = phase_to_duty(pc, mid, per);
        r.motor_tag   = mot;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        n_err++;
        if (n_err <= 40) begin
            $display("MISMATCH %s at %0t ns: got %0d, want %0d", what, $time, got, want);
        end
    endtask

    task automatic queue_cmd(input int trq, input logic brk, input logic [ANG_W-1:0] ang,
                             input logic mot, input bit hold);
        t_pending_cmd p;
        p.cmd.torque_cmd   = TRQ_W'(trq);
        p.cmd.brake_mode   = brk;
        p.cmd.mech_angle   = ang;
        p.cmd.motor_select = mot;
        p.hold             = hold;
        cmd_pend.push_back(p);
    endtask

    task automatic queue_random(input int count, input int hold_at);
        int i;
        int trq;
        for (i = 0; i < count; i++) begin
            if ($urandom_range(0, 3) == 0) begin
                trq = int'($urandom_range(0, 4095)) - 2048;
            end else begin
                trq = int'($urandom_range(0, 2048)) - 1024;
            end
            queue_cmd(trq, 1'($urandom), ANG_W'($urandom), 1'($urandom),
                      (i == hold_at) || ($urandom_range(0, 99) == 0));
        end
    endtask

    task automatic wait_idle();
        while (cmd_pend.size() != 0 || n_sent != n_taken || duty_expect.size() != 0) begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Sender: bursts of words with random gaps; a held word waits for an empty pipe.
    always @(negedge clk) begin : cmd_driver
        t_pending_cmd p;
        if (!rst_n) begin
            cmd_ch.valid <= 1'b0;
        end else if (!cmd_ch.valid || cmd_fire) begin
            if (gap_left > 0) begin
                gap_left--;
                cmd_ch.valid <= 1'b0;
            end else if (cmd_pend.size() != 0 &&
                         !(cmd_pend[0].hold && duty_expect.size() != 0)) begin
                p = cmd_pend.pop_front();
                if (p.hold) begin
                    n_holds++;
                end
                cmd_ch.torque_cmd   <= p.cmd.torque_cmd;
                cmd_ch.brake_mode   <= p.cmd.brake_mode;
                cmd_ch.mech_angle   <= p.cmd.mech_angle;
                cmd_ch.motor_select <= p.cmd.motor_select;
                cmd_ch.valid        <= 1'b1;
                n_sent++;
                burst_left--;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
                end
            end else begin
                cmd_ch.valid <= 1'b0;
            end
        end
    end

    // Receiver: drives ready in one of four randomly chosen stall patterns.
    always @(negedge clk) begin : duty_sink
        if (rx_count % 200 == 0) begin
            rx_mode = t_rx_mode'($urandom_range(0, 3));
        end
        rx_count++;
        case (rx_mode)
            RX_OPEN: begin
                duty_ch.ready <= 1'b1;
            end
            RX_LIGHT: begin
                duty_ch.ready <= ($urandom_range(0, 3) != 0);
            end
            RX_HEAVY: begin
                duty_ch.ready <= ($urandom_range(0, 9) < 3);
            end
            default: begin
                duty_ch.ready <= ((rx_count % 7) < 4);
            end
        endcase
    end

    always @(posedge clk) begin : monitor
        t_duty want;
        cmd_fire <= rst_n && cmd_ch.valid && cmd_ch.ready;
        if (rst_n && cmd_ch.valid && cmd_ch.ready) begin
            duty_expect.push_back(predict_duty(cmd_ch.torque_cmd, cmd_ch.brake_mode,
                                               cmd_ch.mech_angle, cmd_ch.motor_select,
                                               period_now));
            if (cmd_ch.brake_mode) begin
                n_brake++;
            end
            n_taken++;
        end
        if (rst_n && duty_ch.valid && duty_ch.ready) begin
            if (duty_expect.size() == 0) begin
                report_mismatch("unexpected duty word, first", duty_ch.duty_first, -1);
            end else begin
                want = duty_expect.pop_front();
                n_checked++;
                if (duty_ch.duty_first !== want.duty_first) begin
                    report_mismatch("duty_first", duty_ch.duty_first, want.duty_first);
                end
                if (duty_ch.duty_second !== want.duty_second) begin
                    report_mismatch("duty_second", duty_ch.duty_second, want.duty_second);
                end
                if (duty_ch.duty_third !== want.duty_third) begin
                    report_mismatch("duty_third", duty_ch.duty_third, want.duty_third);
                end
                if (duty_ch.motor_tag !== want.motor_tag) begin
                    report_mismatch("motor_tag", duty_ch.motor_tag, want.motor_tag);
                end
            end
        end
    end

    initial begin : stimulus
        int               corner_trq [8];
        logic [ANG_W-1:0] corner_ang [8];
        logic [PER_W-1:0] period_set [8];
        int               i;
        corner_trq = '{1024, -1024, 2047, -2048, 0, 1, -1, 700};
        corner_ang = '{14'd0, 14'd16383, 14'd585, 14'd1170, 14'd8192, 14'd2341, 14'd1, 14'd4096};
        period_set = '{16'd65535, 16'd0, 16'd1, 16'd2, 16'd1000, 16'd0, 16'd0, 16'd1024};
        period_set[5] = PER_W'($urandom_range(3, 65534));
        period_set[6] = PER_W'($urandom_range(3, 65534));

        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_wdata           = '0;
        period_now          = TIMER_PERIOD_RST;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Full-scale and out-of-range torque at angles on quadrant boundaries, both motors.
        for (i = 0; i < 20; i++) begin
            queue_cmd(corner_trq[i % 8], 1'(i % 2), corner_ang[(i * 3) % 8], 1'((i / 2) % 2),
                      1'b0);
        end
        queue_random(150, 60);
        wait_idle();

        // Period register sweep; the block is drained before each write.
        for (i = 0; i < 8; i++) begin
            @(negedge clk);
            cfg_we    <= 1'b1;
            cfg_wdata <= period_set[i];
            @(negedge clk);
            cfg_we     <= 1'b0;
            period_now  = period_set[i];
            n_settings++;
            queue_random(PHASE_ITEMS, -1);
            wait_idle();
        end

        $display("tb: %0d commands over %0d period settings, zero, one, two and 65535 included",
                 n_taken, n_settings);
        $display("tb: %0d duty words checked, %0d in brake mode, %0d holds until drained",
                 n_checked, n_brake, n_holds);
        if (n_err == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
